>>> rtl/egcd_pkg.sv
// ============================================================================
// egcd_pkg: shared types and constants for the extended GCD coefficient unit
// Holds the data width, the controller state encoding and the command and
// status groups exchanged between controller and datapath.
// ============================================================================
package egcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int DIV_CNT_W  = $clog2(DATA_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DIV_WAIT,
        ST_MUL_S,
        ST_MUL_T,
        ST_UPDATE,
        ST_FINISH
    } t_egcd_state;

    typedef struct packed {
        logic load;       // capture operands, set up iteration
        logic start_div;  // launch divider on |old_r| / |r|
        logic take_q;     // latch signed quotient and remainder
        logic mul_s;      // product <= q * s
        logic mul_t;      // new s <= old_s - product, product <= q * t
        logic update;     // shift remainder and coefficient pairs
        logic store_out;  // load output register
    } t_egcd_cmd;

    typedef struct packed {
        logic zero_case;  // an operand was zero
        logic rem_zero;   // current remainder r is zero
        logic div_done;   // divider result available
        logic out_free;   // output register can take a result
    } t_egcd_status;

endpackage

>>> rtl/egcd_if.sv
// ============================================================================
// egcd_req_if / egcd_rsp_if: request and result channels
// Valid/ready channels; a request moves on a clock edge with both high.
// ============================================================================
interface egcd_req_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [egcd_pkg::DATA_WIDTH-1:0]    first_value;
    logic signed [egcd_pkg::DATA_WIDTH-1:0]    second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface egcd_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [egcd_pkg::DATA_WIDTH-1:0]    first_coefficient;
    logic signed [egcd_pkg::DATA_WIDTH-1:0]    second_coefficient;

    modport source (output valid, output first_coefficient, output second_coefficient,
                    input ready);
    modport sink   (input valid, input first_coefficient, input second_coefficient,
                    output ready);
endinterface

>>> rtl/egcd_div.sv
// ============================================================================
// egcd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module egcd_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] i_num,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] i_den,
    output logic                            o_done,
    output logic [egcd_pkg::DATA_WIDTH-1:0] o_quot,
    output logic [egcd_pkg::DATA_WIDTH-1:0] o_rem
);
    localparam int W  = egcd_pkg::DATA_WIDTH;
    localparam int CW = egcd_pkg::DIV_CNT_W;

    logic                           r_busy;
    logic                           r_done;
    logic [CW-1:0]                  r_cnt;
    logic [W-1:0]                   r_rem;
    logic [W-1:0]                   r_quo;   // dividend bits shift out, quotient in
    logic [W-1:0]                   r_den;
    logic [W+1:0]                   trial;

    assign trial = {1'b0, r_rem, r_quo[W-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!trial[W+1]) begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W-2:0], r_quo[W-1]};
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> rtl/egcd_dp.sv
// ============================================================================
// egcd_dp: extended Euclid datapath
// Remainder and coefficient registers, sign handling around the divider,
// one shared multiplier and the output register.
// ============================================================================
module egcd_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  egcd_pkg::t_egcd_cmd             i_cmd,
    output egcd_pkg::t_egcd_status          o_status,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] i_first_value,
    input  logic [egcd_pkg::DATA_WIDTH-1:0] i_second_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [egcd_pkg::DATA_WIDTH-1:0] o_first_coefficient,
    output logic [egcd_pkg::DATA_WIDTH-1:0] o_second_coefficient
);
    localparam int W = egcd_pkg::DATA_WIDTH;

    logic [W-1:0]   r_old_r, r_r, r_old_s, r_s, r_old_t, r_t;
    logic [W-1:0]   r_q, r_rem, r_ns, r_prod;
    logic           r_swapped, r_zero;
    logic           r_out_valid;
    logic [W-1:0]   r_out_x, r_out_y;

    logic           swap_in;
    logic           neg_n, neg_d;
    logic [W-1:0]   mag_n, mag_d;
    logic           div_done;
    logic [W-1:0]   div_quot, div_rem;
    logic [W-1:0]   mul_op;
    logic [W-1:0]   prod_lo;

    assign swap_in = $signed(i_first_value) < $signed(i_second_value);

    assign neg_n = r_old_r[W-1];
    assign neg_d = r_r[W-1];
    assign mag_n = neg_n ? (W'(0) - r_old_r) : r_old_r;
    assign mag_d = neg_d ? (W'(0) - r_r) : r_r;

    egcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (mag_n),
        .i_den   (mag_d),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // only the low word of the product matters, arithmetic wraps
    assign mul_op  = i_cmd.mul_t ? r_t : r_s;
    assign prod_lo = r_q * mul_op;

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero    <= (i_first_value == '0) || (i_second_value == '0);
            r_swapped <= swap_in;
            r_old_r   <= swap_in ? i_second_value : i_first_value;
            r_r       <= swap_in ? i_first_value : i_second_value;
            r_old_s   <= W'(1);
            r_s       <= '0;
            r_old_t   <= '0;
            r_t       <= W'(1);
        end else if (i_cmd.update) begin
            r_old_r <= r_r;
            r_r     <= r_rem;
            r_old_s <= r_s;
            r_s     <= r_ns;
            r_old_t <= r_t;
            r_t     <= r_old_t - r_prod;
        end
        if (i_cmd.take_q) begin
            // truncating division: quotient sign by xor, remainder follows dividend
            r_q   <= (neg_n ^ neg_d) ? (W'(0) - div_quot) : div_quot;
            r_rem <= neg_n ? (W'(0) - div_rem) : div_rem;
        end
        if (i_cmd.mul_s || i_cmd.mul_t) begin
            r_prod <= prod_lo;
        end
        if (i_cmd.mul_t) begin
            r_ns <= r_old_s - r_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.store_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_out) begin
            if (r_zero) begin
                r_out_x <= '0;
                r_out_y <= '0;
            end else if (r_swapped) begin
                r_out_x <= r_old_t;
                r_out_y <= r_old_s;
            end else begin
                r_out_x <= r_old_s;
                r_out_y <= r_old_t;
            end
        end
    end

    assign o_status.zero_case = r_zero;
    assign o_status.rem_zero  = (r_r == '0);
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid          = r_out_valid;
    assign o_first_coefficient  = r_out_x;
    assign o_second_coefficient = r_out_y;

endmodule

>>> rtl/egcd_ctrl.sv
// ============================================================================
// egcd_ctrl: extended Euclid sequencer
// Steps each iteration through divide, two multiply-subtracts and update.
// ============================================================================
module egcd_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  egcd_pkg::t_egcd_status i_status,
    output egcd_pkg::t_egcd_cmd    o_cmd,
    output egcd_pkg::t_egcd_state  o_state
);
    egcd_pkg::t_egcd_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= egcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            egcd_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = egcd_pkg::ST_CHECK;
            end
            egcd_pkg::ST_CHECK: begin
                if (i_status.zero_case || i_status.rem_zero) n_state = egcd_pkg::ST_FINISH;
                else                                          n_state = egcd_pkg::ST_DIV;
            end
            egcd_pkg::ST_DIV:      n_state = egcd_pkg::ST_DIV_WAIT;
            egcd_pkg::ST_DIV_WAIT: begin
                if (i_status.div_done) n_state = egcd_pkg::ST_MUL_S;
            end
            egcd_pkg::ST_MUL_S:    n_state = egcd_pkg::ST_MUL_T;
            egcd_pkg::ST_MUL_T:    n_state = egcd_pkg::ST_UPDATE;
            egcd_pkg::ST_UPDATE:   n_state = egcd_pkg::ST_CHECK;
            egcd_pkg::ST_FINISH: begin
                if (i_status.out_free) n_state = egcd_pkg::ST_IDLE;
            end
            default:               n_state = egcd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            egcd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            egcd_pkg::ST_CHECK:    ;
            egcd_pkg::ST_DIV:      o_cmd.start_div = 1'b1;
            egcd_pkg::ST_DIV_WAIT: o_cmd.take_q    = i_status.div_done;
            egcd_pkg::ST_MUL_S:    o_cmd.mul_s     = 1'b1;
            egcd_pkg::ST_MUL_T:    o_cmd.mul_t     = 1'b1;
            egcd_pkg::ST_UPDATE:   o_cmd.update    = 1'b1;
            egcd_pkg::ST_FINISH:   o_cmd.store_out = i_status.out_free;
            default:               ;
        endcase
    end

    assign o_state = r_state;

endmodule

>>> rtl/extended_gcd_coefficients.sv
// ============================================================================
// extended_gcd_coefficients: Bezout coefficients of two signed operands
// Each Euclid iteration runs one full divider pass, up to ~46 iterations
// at 32 bits. A zero operand skips the division loop.
// Throughput: one request at a time; the next can be taken in the cycle
// after the result is stored. The 1-bit-per-cycle divider dominates.
// A new request is taken while the old result waits in the output register.
// Reset (i_rst_n low, synchronous) idles the sequencer, clears the divider
// and drops the output valid.
// ============================================================================
module extended_gcd_coefficients (
    input  logic              i_clk,
    input  logic              i_rst_n,
    egcd_req_if.sink          i_req,
    egcd_rsp_if.source        o_rsp
);
    // Sequencer and datapath talk only through the command and status groups.
    egcd_pkg::t_egcd_cmd    cmd;
    egcd_pkg::t_egcd_status status;
    egcd_pkg::t_egcd_state  state;
    logic                   in_ready;

    // Controller: one pass per iteration is CHECK, DIV, DIV_WAIT, MUL_S,
    // MUL_T, UPDATE. The loop leaves when the remainder is zero; its
    // magnitude shrinks every pass, so no iteration guard is needed.
    egcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    // Datapath: the operand larger as a signed number becomes the dividend;
    // coefficients are swapped back on output. Zero operands give (0,0).
    egcd_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_first_value        (i_req.first_value),
        .i_second_value       (i_req.second_value),
        .o_out_valid          (o_rsp.valid),
        .i_out_ready          (o_rsp.ready),
        .o_first_coefficient  (o_rsp.first_coefficient),
        .o_second_coefficient (o_rsp.second_coefficient)
    );

    assign i_req.ready = in_ready;

    // A request moves the sequencer out of idle, so ready drops right after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("ready stayed high after a request was taken");

    // A result appears only when the sequencer finished a request.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(cmd.store_out))
        else $error("result valid without a store");

    // Divider done must clear after a launch, so no stale quotient is taken.
    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start_div |=> (!status.div_done && state == egcd_pkg::ST_DIV_WAIT))
        else $error("stale divider result after launch");

endmodule
